### rtl/segint_pkg.sv
// Package for the segment intersection pipeline: shared types and constants.
package segint_pkg;

   // Coordinates carry this many fraction bits; areas and the tolerance carry twice as many.
   localparam int FRAC_BITS = 12;

   localparam int TOL_BITS = 50;
   localparam logic [TOL_BITS-1:0] TOL_RESET = 50'd168;

   typedef enum logic [1:0] {
      TOUCH_NONE  = 2'd0,
      TOUCH_END   = 2'd1,
      TOUCH_START = 2'd2
   } touch_type;

endpackage

### rtl/segint_div.sv
// Pipelined restoring divider for the crossing ratio, one quotient bit per stage.
module segint_div
   import segint_pkg::*;
#(
   parameter int NUM_BITS = 64,
   parameter int Q_BITS = 24,
   parameter int SIDE_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [NUM_BITS-1:0]  in_num,
   input  logic [NUM_BITS-1:0]  in_den,
   input  logic [SIDE_BITS-1:0] in_side,
   output logic                 out_valid,
   output logic [Q_BITS-1:0]    out_quot,
   output logic [SIDE_BITS-1:0] out_side
);

   logic [Q_BITS:0]         valid_ff;
   logic [NUM_BITS:0]       num_ff [Q_BITS];
   logic [NUM_BITS-1:0]     den_ff [Q_BITS];
   logic [Q_BITS-1:0]       quot_ff [Q_BITS+1];
   logic [SIDE_BITS-1:0]    side_ff [Q_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[Q_BITS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff[0]  <= {1'b0, in_num};
         den_ff[0]  <= in_den;
         quot_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < Q_BITS; k++) begin : g_step
      logic [NUM_BITS+1:0] shifted;
      logic                take;
      assign shifted = {num_ff[k], 1'b0};
      assign take = shifted >= {2'b00, den_ff[k]};
      always_ff @(posedge clock) begin
         if (advance) begin
            quot_ff[k+1] <= {quot_ff[k][Q_BITS-2:0], take};
            side_ff[k+1] <= side_ff[k];
         end
      end
      if (k < Q_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               num_ff[k+1] <= take ? (NUM_BITS+1)'(shifted - {2'b00, den_ff[k]})
                                   : shifted[NUM_BITS:0];
               den_ff[k+1] <= den_ff[k];
            end
         end
      end
   end

   assign out_valid = valid_ff[Q_BITS];
   assign out_quot  = quot_ff[Q_BITS];
   assign out_side  = side_ff[Q_BITS];

endmodule

### rtl/segment_intersection_2d.sv
// Top level of the pipelined 2D segment crossing test with interpolated z.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, ten coordinate words
//   rsp     | out       | rsp_valid, rsp_stall, hit, cross xyz, touch_code
//   csr     | in        | csr_write, csr_data (colinear tolerance)
//
// One word enters per cycle while no valid response word is stalled. Most of the
// pipeline is the divider for the ratio, with its input stage and one stage per quotient bit.
// Reset clears the valid bits and loads the tolerance default. A stalled output
// word freezes the whole pipeline, so the request side stalls exactly while a
// valid response word is stalled.
module segment_intersection_2d
   import segint_pkg::*;
#(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_p1_x,
   input  logic signed [COORD_BITS-1:0] req_p1_y,
   input  logic signed [COORD_BITS-1:0] req_p1_z,
   input  logic signed [COORD_BITS-1:0] req_q1_x,
   input  logic signed [COORD_BITS-1:0] req_q1_y,
   input  logic signed [COORD_BITS-1:0] req_q1_z,
   input  logic signed [COORD_BITS-1:0] req_p2_x,
   input  logic signed [COORD_BITS-1:0] req_p2_y,
   input  logic signed [COORD_BITS-1:0] req_q2_x,
   input  logic signed [COORD_BITS-1:0] req_q2_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit,
   output logic signed [COORD_BITS-1:0] rsp_cross_x,
   output logic signed [COORD_BITS-1:0] rsp_cross_y,
   output logic signed [COORD_BITS-1:0] rsp_cross_z,
   output logic [1:0]                   rsp_touch_code,
   input  logic                         csr_write,
   input  logic [TOL_BITS-1:0]          csr_data
);

   localparam int T_BITS = 24;
   localparam int D_BITS = COORD_BITS + 1;
   localparam int P_BITS = 2 * D_BITS;
   localparam int A_BITS = P_BITS + 2;
   localparam int M_BITS = A_BITS + 1;
   localparam int SIDE_BITS = 6 * COORD_BITS;
   localparam int L_BITS = T_BITS + D_BITS + 2;

   logic                advance;
   logic [TOL_BITS-1:0] tol_ff;

   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_write) begin
         tol_ff <= csr_data;
      end
   end

   // Stage 1: differences.
   logic                      s1_valid_ff;
   logic signed [D_BITS-1:0]  s1_bxd_ff, s1_byd_ff, s1_axd_ff, s1_ayd_ff;
   logic signed [D_BITS-1:0]  s1_bxc_ff, s1_byc_ff, s1_axc_ff, s1_ayc_ff;
   logic signed [D_BITS-1:0]  s1_cxa_ff, s1_cya_ff, s1_dxa_ff, s1_dya_ff;
   logic signed [COORD_BITS-1:0] s1_ax_ff, s1_ay_ff, s1_az_ff;
   logic signed [COORD_BITS-1:0] s1_bx_ff, s1_by_ff, s1_bz_ff;
   logic signed [COORD_BITS-1:0] s1_cx_ff, s1_cy_ff, s1_dx_ff, s1_dy_ff;

   function automatic logic signed [D_BITS-1:0] diff(input logic signed [COORD_BITS-1:0] a,
                                                     input logic signed [COORD_BITS-1:0] b);
      diff = D_BITS'(a) - D_BITS'(b);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_axd_ff <= diff(req_p1_x, req_q2_x);
         s1_ayd_ff <= diff(req_p1_y, req_q2_y);
         s1_bxd_ff <= diff(req_q1_x, req_q2_x);
         s1_byd_ff <= diff(req_q1_y, req_q2_y);
         s1_axc_ff <= diff(req_p1_x, req_p2_x);
         s1_ayc_ff <= diff(req_p1_y, req_p2_y);
         s1_bxc_ff <= diff(req_q1_x, req_p2_x);
         s1_byc_ff <= diff(req_q1_y, req_p2_y);
         s1_cxa_ff <= diff(req_p2_x, req_p1_x);
         s1_cya_ff <= diff(req_p2_y, req_p1_y);
         s1_dxa_ff <= diff(req_q2_x, req_p1_x);
         s1_dya_ff <= diff(req_q2_y, req_p1_y);
         s1_ax_ff <= req_p1_x;
         s1_ay_ff <= req_p1_y;
         s1_az_ff <= req_p1_z;
         s1_bx_ff <= req_q1_x;
         s1_by_ff <= req_q1_y;
         s1_bz_ff <= req_q1_z;
         s1_cx_ff <= req_p2_x;
         s1_cy_ff <= req_p2_y;
         s1_dx_ff <= req_q2_x;
         s1_dy_ff <= req_q2_y;
      end
   end

   // Stage 2: products and span checks.
   logic                     s2_valid_ff;
   logic signed [P_BITS-1:0] s2_p1a_ff, s2_p1b_ff, s2_p2a_ff, s2_p2b_ff;
   logic signed [P_BITS-1:0] s2_p3a_ff, s2_p3b_ff;
   logic                     s2_tin_ff, s2_cin_ff;
   logic signed [COORD_BITS-1:0] s2_ax_ff, s2_ay_ff, s2_az_ff;
   logic signed [COORD_BITS-1:0] s2_bx_ff, s2_by_ff, s2_bz_ff;

   function automatic logic in_range(input logic signed [COORD_BITS-1:0] a,
                                     input logic signed [COORD_BITS-1:0] b,
                                     input logic signed [COORD_BITS-1:0] p);
      in_range = (a < b) ? (p >= a && p <= b) : (p >= b && p <= a);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_p1a_ff <= P_BITS'(s1_axd_ff) * P_BITS'(s1_byd_ff);
         s2_p1b_ff <= P_BITS'(s1_ayd_ff) * P_BITS'(s1_bxd_ff);
         s2_p2a_ff <= P_BITS'(s1_axc_ff) * P_BITS'(s1_byc_ff);
         s2_p2b_ff <= P_BITS'(s1_ayc_ff) * P_BITS'(s1_bxc_ff);
         s2_p3a_ff <= P_BITS'(s1_cxa_ff) * P_BITS'(s1_dya_ff);
         s2_p3b_ff <= P_BITS'(s1_cya_ff) * P_BITS'(s1_dxa_ff);
         if (s1_ax_ff != s1_bx_ff) begin
            s2_tin_ff <= in_range(s1_ax_ff, s1_bx_ff, s1_dx_ff);
            s2_cin_ff <= in_range(s1_ax_ff, s1_bx_ff, s1_cx_ff);
         end else begin
            s2_tin_ff <= in_range(s1_ay_ff, s1_by_ff, s1_dy_ff);
            s2_cin_ff <= in_range(s1_ay_ff, s1_by_ff, s1_cy_ff);
         end
         s2_ax_ff <= s1_ax_ff;
         s2_ay_ff <= s1_ay_ff;
         s2_az_ff <= s1_az_ff;
         s2_bx_ff <= s1_bx_ff;
         s2_by_ff <= s1_by_ff;
         s2_bz_ff <= s1_bz_ff;
      end
   end

   // Stage 3: areas, signs, touch and divider operands.
   logic signed [A_BITS-1:0] a1, a2, a3, a4;
   logic [M_BITS-1:0]        m3, m4;
   logic                     hit_w;
   touch_type                touch_w;

   function automatic logic [M_BITS-1:0] magn(input logic signed [A_BITS-1:0] v);
      magn = v[A_BITS-1] ? M_BITS'(-v) : M_BITS'(v);
      magn[M_BITS-1] = 1'b0;
      if (v[A_BITS-1]) magn = M_BITS'(-{v[A_BITS-1], v});
   endfunction

   always_comb begin
      a1 = A_BITS'(s2_p1a_ff) - A_BITS'(s2_p1b_ff);
      a2 = A_BITS'(s2_p2a_ff) - A_BITS'(s2_p2b_ff);
      a3 = A_BITS'(s2_p3a_ff) - A_BITS'(s2_p3b_ff);
      a4 = a3 + a2 - a1;
      m3 = magn(a3);
      m4 = magn(a4);
      hit_w = (a1 != '0) && (a2 != '0) && (a1[A_BITS-1] != a2[A_BITS-1]) &&
              (a3 != '0) && (a4 != '0) && (a3[A_BITS-1] != a4[A_BITS-1]);
      if (hit_w) begin
         touch_w = TOUCH_NONE;
      end else if ({{(TOL_BITS+1){1'b0}}, magn(a1)} < {{(M_BITS+1){1'b0}}, tol_ff}
                   && s2_tin_ff) begin
         touch_w = TOUCH_END;
      end else if ({{(TOL_BITS+1){1'b0}}, magn(a2)} < {{(M_BITS+1){1'b0}}, tol_ff}
                   && s2_cin_ff) begin
         touch_w = TOUCH_START;
      end else begin
         touch_w = TOUCH_NONE;
      end
   end

   logic                 s3_valid_ff;
   logic [M_BITS:0]      s3_num_ff, s3_den_ff;
   logic [SIDE_BITS+2:0] s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_num_ff  <= {1'b0, m3};
         s3_den_ff  <= {1'b0, m3} + {1'b0, m4};
         s3_side_ff <= {touch_w, hit_w, s2_ax_ff, s2_ay_ff, s2_az_ff,
                        s2_bx_ff, s2_by_ff, s2_bz_ff};
      end
   end

   logic                 dv_valid;
   logic [T_BITS-1:0]    dv_quot;
   logic [SIDE_BITS+2:0] dv_side;

   segint_div #(
      .NUM_BITS (M_BITS + 1),
      .Q_BITS   (T_BITS),
      .SIDE_BITS(SIDE_BITS + 3)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (s3_valid_ff),
      .in_num   (s3_num_ff),
      .in_den   (s3_den_ff),
      .in_side  (s3_side_ff),
      .out_valid(dv_valid),
      .out_quot (dv_quot),
      .out_side (dv_side)
   );

   // Interpolation: difference, product, then rounding.
   logic signed [COORD_BITS-1:0] d_ax, d_ay, d_az, d_bx, d_by, d_bz;
   logic                         d_hit;
   logic [1:0]                   d_touch;

   assign {d_touch, d_hit, d_ax, d_ay, d_az, d_bx, d_by, d_bz} = dv_side;

   logic                         s4_valid_ff, s4_hit_ff;
   logic [1:0]                   s4_touch_ff;
   logic [T_BITS-1:0]            s4_t_ff;
   logic signed [D_BITS-1:0]     s4_ex_ff, s4_ey_ff, s4_ez_ff;
   logic signed [COORD_BITS-1:0] s4_ax_ff, s4_ay_ff, s4_az_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_hit_ff   <= d_hit;
         s4_touch_ff <= d_touch;
         s4_t_ff     <= dv_quot;
         s4_ex_ff    <= diff(d_bx, d_ax);
         s4_ey_ff    <= diff(d_by, d_ay);
         s4_ez_ff    <= diff(d_bz, d_az);
         s4_ax_ff    <= d_ax;
         s4_ay_ff    <= d_ay;
         s4_az_ff    <= d_az;
      end
   end

   logic                         s5_valid_ff, s5_hit_ff;
   logic [1:0]                   s5_touch_ff;
   logic signed [L_BITS-1:0]     s5_mx_ff, s5_my_ff, s5_mz_ff;
   logic signed [COORD_BITS-1:0] s5_ax_ff, s5_ay_ff, s5_az_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_hit_ff   <= s4_hit_ff;
         s5_touch_ff <= s4_touch_ff;
         s5_mx_ff <= L_BITS'(signed'({1'b0, s4_t_ff})) * L_BITS'(s4_ex_ff);
         s5_my_ff <= L_BITS'(signed'({1'b0, s4_t_ff})) * L_BITS'(s4_ey_ff);
         s5_mz_ff <= L_BITS'(signed'({1'b0, s4_t_ff})) * L_BITS'(s4_ez_ff);
         s5_ax_ff <= s4_ax_ff;
         s5_ay_ff <= s4_ay_ff;
         s5_az_ff <= s4_az_ff;
      end
   end

   // Adding half and shifting arithmetically rounds halves toward plus infinity.
   function automatic logic signed [COORD_BITS-1:0] finish(
         input logic signed [COORD_BITS-1:0] a, input logic signed [L_BITS-1:0] m);
      logic signed [L_BITS-1:0] w;
      w = m + (L_BITS'(1) <<< (T_BITS - 1));
      finish = a + COORD_BITS'(w >>> T_BITS);
   endfunction

   logic                         out_valid_ff, out_hit_ff;
   logic [1:0]                   out_touch_ff;
   logic signed [COORD_BITS-1:0] out_x_ff, out_y_ff, out_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_hit_ff   <= s5_hit_ff;
         out_touch_ff <= s5_touch_ff;
         out_x_ff <= s5_hit_ff ? finish(s5_ax_ff, s5_mx_ff) : '0;
         out_y_ff <= s5_hit_ff ? finish(s5_ay_ff, s5_my_ff) : '0;
         out_z_ff <= s5_hit_ff ? finish(s5_az_ff, s5_mz_ff) : '0;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_hit        = out_hit_ff;
   assign rsp_touch_code = out_touch_ff;
   assign rsp_cross_x    = out_x_ff;
   assign rsp_cross_y    = out_y_ff;
   assign rsp_cross_z    = out_z_ff;

endmodule

### tb/segment_intersection_2d_checker.sv
// Checker that predicts and compares every response word of the segment crossing block.
`timescale 1ns / 1ps
module segment_intersection_2d_checker
   import segint_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [23:0] req_p1_x,
   input  logic signed [23:0] req_p1_y,
   input  logic signed [23:0] req_p1_z,
   input  logic signed [23:0] req_q1_x,
   input  logic signed [23:0] req_q1_y,
   input  logic signed [23:0] req_q1_z,
   input  logic signed [23:0] req_p2_x,
   input  logic signed [23:0] req_p2_y,
   input  logic signed [23:0] req_q2_x,
   input  logic signed [23:0] req_q2_y,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_hit,
   input  logic signed [23:0] rsp_cross_x,
   input  logic signed [23:0] rsp_cross_y,
   input  logic signed [23:0] rsp_cross_z,
   input  logic [1:0]         rsp_touch_code,
   input  logic               csr_write,
   input  logic [TOL_BITS-1:0] csr_data,
   output int                 fail_count,
   output int                 pending_count,
   output int                 hit_count,
   output int                 touch_count
);

   typedef struct packed {
      logic               hit;
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
      touch_type          touch;
   } crossing_t;

   crossing_t expected_crossings[$];
   logic [TOL_BITS-1:0] tolerance;

   function automatic longint signed area(longint signed ax, longint signed ay,
         longint signed bx, longint signed by, longint signed cx, longint signed cy);
      return (ax - cx) * (by - cy) - (ay - cy) * (bx - cx);
   endfunction

   function automatic longint signed magnitude(longint signed v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint signed interpolate(longint signed a, longint signed b,
         longint signed t);
      longint signed w;
      w = t * (b - a) + (64'sd1 <<< 23);
      if (w >= 0) begin
         return a + (w >>> 24);
      end
      return a - ((-w + (64'sd1 <<< 24) - 1) >>> 24);
   endfunction

   function automatic logic within_span(longint signed ax, longint signed ay,
         longint signed bx, longint signed by, longint signed px, longint signed py);
      if (ax != bx) begin
         return px >= (ax < bx ? ax : bx) && px <= (ax < bx ? bx : ax);
      end
      return py >= (ay < by ? ay : by) && py <= (ay < by ? by : ay);
   endfunction

   function automatic crossing_t predict_crossing();
      crossing_t r;
      longint signed ax, ay, bx, by, cx, cy, dx, dy, a1, a2, a3, a4, num, den, q;
      ax = longint'(req_p1_x); ay = longint'(req_p1_y);
      bx = longint'(req_q1_x); by = longint'(req_q1_y);
      cx = longint'(req_p2_x); cy = longint'(req_p2_y);
      dx = longint'(req_q2_x); dy = longint'(req_q2_y);
      r = '0;
      r.touch = TOUCH_NONE;
      a1 = area(ax, ay, bx, by, dx, dy);
      a2 = area(ax, ay, bx, by, cx, cy);
      if ((a1 > 0 && a2 < 0) || (a1 < 0 && a2 > 0)) begin
         a3 = area(cx, cy, dx, dy, ax, ay);
         a4 = a3 + a2 - a1;
         if ((a3 > 0 && a4 < 0) || (a3 < 0 && a4 > 0)) begin
            num = magnitude(a3);
            den = num + magnitude(a4);
            q = 0;
            for (int k = 0; k < 24; k++) begin
               num = num <<< 1;
               q = q <<< 1;
               if (num >= den) begin
                  num = num - den;
                  q = q | 1;
               end
            end
            r.hit = 1'b1;
            r.x = 24'(interpolate(ax, bx, q));
            r.y = 24'(interpolate(ay, by, q));
            r.z = 24'(interpolate(longint'(req_p1_z), longint'(req_q1_z), q));
            return r;
         end
      end
      if (magnitude(a1) < longint'({14'd0, tolerance}) && within_span(ax, ay, bx, by, dx, dy))
      begin
         r.touch = TOUCH_END;
      end else if (magnitude(a2) < longint'({14'd0, tolerance})
            && within_span(ax, ay, bx, by, cx, cy)) begin
         r.touch = TOUCH_START;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   always @(posedge clock) begin
      crossing_t e;
      if (reset) begin
         tolerance <= TOL_RESET;
         expected_crossings.delete();
         fail_count = 0;
         hit_count <= 0;
         touch_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_crossings.push_back(predict_crossing());
         end
         if (csr_write) begin
            tolerance <= csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_crossings.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               e = expected_crossings.pop_front();
               if (e.hit) hit_count <= hit_count + 1;
               if (e.touch != TOUCH_NONE) touch_count <= touch_count + 1;
               if (rsp_hit !== e.hit) begin
                  report_mismatch("hit", longint'(rsp_hit), longint'(e.hit));
               end
               if (rsp_cross_x !== e.x) begin
                  report_mismatch("cross_x", longint'(rsp_cross_x), longint'(e.x));
               end
               if (rsp_cross_y !== e.y) begin
                  report_mismatch("cross_y", longint'(rsp_cross_y), longint'(e.y));
               end
               if (rsp_cross_z !== e.z) begin
                  report_mismatch("cross_z", longint'(rsp_cross_z), longint'(e.z));
               end
               if (rsp_touch_code !== e.touch) begin
                  report_mismatch("touch_code", longint'(rsp_touch_code), longint'(e.touch));
               end
            end
         end
      end
      pending_count = expected_crossings.size();
   end

endmodule

### tb/segment_intersection_2d_tb.sv
// Top of the segment crossing testbench: stimulus, idling, pressure and verdict.
`timescale 1ns / 1ps
module segment_intersection_2d_tb;
   import segint_pkg::*;

   localparam int LATENCY = 31;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [23:0] p1_x = '0, p1_y = '0, p1_z = '0, q1_x = '0, q1_y = '0, q1_z = '0;
   logic signed [23:0] p2_x = '0, p2_y = '0, q2_x = '0, q2_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit;
   logic signed [23:0] rsp_cross_x, rsp_cross_y, rsp_cross_z;
   logic [1:0] rsp_touch_code;
   logic csr_write = 1'b0;
   logic [TOL_BITS-1:0] csr_data = '0;
   int fail_count, pending_count, hit_count, touch_count;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic hold_request = 1'b0;
   logic hold_taken = 1'b0;
   int hold_cycles = 0;
   int word_count = 0;

   always #5 clock = ~clock;

   segment_intersection_2d u_top (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_p1_x(p1_x), .req_p1_y(p1_y), .req_p1_z(p1_z),
      .req_q1_x(q1_x), .req_q1_y(q1_y), .req_q1_z(q1_z),
      .req_p2_x(p2_x), .req_p2_y(p2_y), .req_q2_x(q2_x), .req_q2_y(q2_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y), .rsp_cross_z(rsp_cross_z),
      .rsp_touch_code(rsp_touch_code), .csr_write(csr_write), .csr_data(csr_data)
   );

   segment_intersection_2d_checker u_checker (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_p1_x(p1_x), .req_p1_y(p1_y), .req_p1_z(p1_z),
      .req_q1_x(q1_x), .req_q1_y(q1_y), .req_q1_z(q1_z),
      .req_p2_x(p2_x), .req_p2_y(p2_y), .req_q2_x(q2_x), .req_q2_y(q2_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y), .rsp_cross_z(rsp_cross_z),
      .rsp_touch_code(rsp_touch_code), .csr_write(csr_write), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .hit_count(hit_count), .touch_count(touch_count)
   );

   // The receiver stalls at random, or solidly while a long hold-off runs.
   always @(posedge clock) begin
      if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_cycles <= 80;
         rsp_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic logic signed [23:0] any_coord();
      case ($urandom_range(5))
         0: return 24'sh7fffff;
         1: return 24'sh800000;
         2: return 24'($urandom);
         default: return $signed(24'($urandom_range(8191))) - 24'sd4096;
      endcase
   endfunction

   task automatic send_word(logic signed [23:0] ax, ay, az, bx, by, bz, cx, cy, dx, dy);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      p1_x <= ax; p1_y <= ay; p1_z <= az; q1_x <= bx; q1_y <= by; q1_z <= bz;
      p2_x <= cx; p2_y <= cy; q2_x <= dx; q2_y <= dy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      word_count++;
   endtask

   // Coordinates mix modest values, extremes and full-range noise, with a share of crossings and touches.
   task automatic send_random();
      logic signed [23:0] ax, ay, bx, by, cx, cy, dx, dy;
      int s;
      s = $urandom_range(9);
      ax = any_coord(); ay = any_coord(); bx = any_coord(); by = any_coord();
      cx = any_coord(); cy = any_coord(); dx = any_coord(); dy = any_coord();
      if (s < 4) begin
         // Second segment through the first segment's midpoint.
         cx = (ax >>> 1) + (bx >>> 1) + (ay - by) / 4;
         cy = (ay >>> 1) + (by >>> 1) + (bx - ax) / 4;
         dx = (ax >>> 1) + (bx >>> 1) - (ay - by) / 4;
         dy = (ay >>> 1) + (by >>> 1) - (bx - ax) / 4;
      end else if (s < 6) begin
         // A second-segment end lying on the first segment.
         by = ay;
         if ($urandom_range(1)) begin
            dx = (ax >>> 1) + (bx >>> 1); dy = ay;
         end else begin
            cx = (ax >>> 1) + (bx >>> 1); cy = ay;
         end
      end else if (s == 6) begin
         bx = ax;
         cx = ax; cy = (ay >>> 1) + (by >>> 1);
      end
      send_word(ax, ay, any_coord(), bx, by, any_coord(), cx, cy, dx, dy);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [TOL_BITS-1:0] value);
      csr_write <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words: crossings, touches at each end, extremes, degenerate segments.
      send_word(0, 0, 0, 24'sd8192, 24'sd8192, 24'sd4096, 0, 24'sd8192, 24'sd8192, 0);
      send_word(24'sh800000, 24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh7fffff,
                24'sh7fffff, 24'sh800000, 24'sh7fffff, 24'sh7fffff, 24'sh800000);
      send_word(0, 0, 0, 24'sd4096, 0, 0, 24'sd100, 24'sd50, 24'sd2000, 0);
      send_word(0, 0, 0, 24'sd4096, 0, 0, 24'sd2000, 0, 24'sd100, 24'sd50);
      send_word(0, 0, 0, 0, 24'sd4096, 0, 0, 24'sd500, 24'sd300, 24'sd300);
      send_word(24'sd5, 24'sd5, 0, 24'sd5, 24'sd5, 0, 24'sd7, 24'sd5, 24'sd9, 24'sd9);
      send_word(0, 0, 0, 24'sd4096, 0, 0, 24'sd4096, 24'sd10, 24'sd8192, 24'sd10);
      send_word(0, 0, 0, 24'sd4096, 0, 0, 24'sd5000, 0, 24'sd6000, 0);
      send_word(24'sh7fffff, 0, 24'sh800000, 24'sh800000, 0, 24'sh7fffff,
                0, 24'sh7fffff, 0, 24'sh800000);
      send_word(24'sh7fffff, 24'sh7fffff, 0, 24'sh7fffff, 24'sh7fffff, 0,
                24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh800000);
      drain();
      write_tolerance('0);
      send_word(0, 0, 0, 24'sd4096, 0, 0, 24'sd100, 0, 24'sd200, 0);
      drain();
      write_tolerance({TOL_BITS{1'b1}});
      send_word(0, 0, 0, 24'sd4096, 0, 0, 24'sd100, 24'sh7fffff, 24'sd200, 24'sh7fffff);
      send_word(0, 0, 0, 0, 0, 0, 24'sd3, 24'sd0, 24'sd9, 24'sd9);
      drain();
      write_tolerance(TOL_RESET);

      send_idle_pct = 38; recv_idle_pct = 64;
      repeat (150) send_random();
      // Long receiver hold-off while words keep coming, so the pipeline backs up.
      hold_request = 1'b1;
      repeat (60) send_random();
      drain();
      write_tolerance(50'd1 << 30);
      send_idle_pct = 64; recv_idle_pct = 38;
      repeat (150) send_random();
      drain();
      write_tolerance(50'($urandom_range(4000)));
      send_idle_pct = 0; recv_idle_pct = 0;
      repeat (150) send_random();
      drain();

      $display("Covered %0d words: %0d crossings and %0d touches across five tolerances,",
               word_count, hit_count, touch_count);
      $display("with random idling on both sides and a long response hold-off.");
      if (fail_count == 0) begin
         $display("segment_intersection_2d_tb: PASS");
      end else begin
         $display("segment_intersection_2d_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("segment_intersection_2d_tb: FAIL");
      $finish;
   end

endmodule

### filelist.f
rtl/segint_pkg.sv
rtl/segint_div.sv
rtl/segment_intersection_2d.sv
tb/segment_intersection_2d_checker.sv
tb/segment_intersection_2d_tb.sv
